/* rtl/dblmc_pkg.sv */
// Shared types, codes and constants of the debounced button LED mode controller.
package dblmc_pkg;

   localparam int DEBOUNCE_SAMPLES_DEF = 5;

   localparam logic [7:0] BLINK_PERIOD_RESET   = 8'd5;
   localparam logic [7:0] BLINK_DURATION_RESET = 8'd50;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLINK_PERIOD   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLINK_DURATION = 2'd1;

   // LED command bytes: 'A'..'D' on, 'E'..'H' off
   localparam logic [7:0] CODE_LED0_ON  = 8'h41;
   localparam logic [7:0] CODE_LED1_ON  = 8'h42;
   localparam logic [7:0] CODE_LED2_ON  = 8'h43;
   localparam logic [7:0] CODE_LED3_ON  = 8'h44;
   localparam logic [7:0] CODE_LED0_OFF = 8'h45;
   localparam logic [7:0] CODE_LED1_OFF = 8'h46;
   localparam logic [7:0] CODE_LED2_OFF = 8'h47;
   localparam logic [7:0] CODE_LED3_OFF = 8'h48;
   localparam logic [7:0] CODE_NONE     = 8'h00;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      MODE_NORMAL   = 2'd0,
      MODE_STOPPED  = 2'd1,
      MODE_BLINKING = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_DIV,
      FE_PUSH
   } front_state_type;

   typedef struct packed {
      logic raw_button0;
      logic raw_button1;
      logic raw_button2;
      logic raw_button3;
   } req_type;

   typedef struct packed {
      logic       is_code;
      logic [7:0] code_byte;
      logic [1:0] mode_now;
      logic       led1_on;
      logic       led2_on;
      logic       led3_on;
      logic       blink_level;
      logic       last_of_tick;
   } rsp_type;

   // What one tick has to send, as classified by the front end
   typedef struct packed {
      logic [2:0] toggle;      // LED1..3 toggled in normal mode
      logic       stop_seq;    // entered stopped: F G H A
      logic       norm_seq;    // returned to normal: E then LED1..3 state
      logic [2:0] leds;        // LED1..3 state after the tick
      mode_type   mode;
      logic       blink;
   } task_type;

endpackage

/* rtl/dblmc_front.sv */
// Front end: debounce, mode machine and per-tick task classification.
module dblmc_front #(
   parameter int DEBOUNCE_SAMPLES = dblmc_pkg::DEBOUNCE_SAMPLES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  dblmc_pkg::req_type req_data,
   input  logic [7:0]         blink_period,
   input  logic [7:0]         blink_duration,
   output logic               push_valid,
   output dblmc_pkg::task_type push_data,
   input  logic               queue_full
);
   import dblmc_pkg::*;

   front_state_type fe_state_ff, fe_state_in;

   logic [3:0] pressed_ff, pressed_in;
   logic [8:0] rem_ff, rem_in;
   logic [2:0] bit_ff, bit_in;

   logic [DEBOUNCE_SAMPLES-1:0] hist_ff [4];
   logic [DEBOUNCE_SAMPLES-1:0] hist_in [4];
   logic [3:0] deb_ff, deb_in;
   logic [3:0] prev_ff, prev_in;
   logic [2:0] led_ff, led_in;
   mode_type   mode_ff, mode_in;
   logic [7:0] cnt_ff, cnt_in;
   logic       blink_ff, blink_in;

   logic       accept;
   logic       commit;
   logic [8:0] divisor;
   logic [8:0] rem_shift;
   logic [3:0] edge_det;
   logic [7:0] cnt_next;
   task_type   task_out;

   assign accept  = req_valid && !req_stall;
   assign commit  = (fe_state_ff == FE_PUSH) && !queue_full;
   // period 0 counts as 256
   assign divisor = {(blink_period == 8'd0), blink_period};
   assign rem_shift = {rem_ff[7:0], cnt_ff[bit_ff]};
   assign cnt_next  = cnt_ff + 8'd1;

   // next state
   always_comb begin
      fe_state_in = fe_state_ff;
      case (fe_state_ff)
         FE_IDLE: if (req_valid) fe_state_in = FE_DIV;
         FE_DIV:  if (bit_ff == 3'd0) fe_state_in = FE_PUSH;
         FE_PUSH: if (!queue_full) fe_state_in = FE_IDLE;
         default: fe_state_in = FE_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall  = 1'b1;
      push_valid = 1'b0;
      case (fe_state_ff)
         FE_IDLE: req_stall = 1'b0;
         FE_PUSH: push_valid = 1'b1;
         default: ;
      endcase
   end

   // remainder of the blink counter by the period, one bit per cycle
   always_comb begin
      pressed_in = pressed_ff;
      rem_in     = rem_ff;
      bit_in     = bit_ff;
      if (accept) begin
         pressed_in = ~{req_data.raw_button3, req_data.raw_button2,
                        req_data.raw_button1, req_data.raw_button0};
         rem_in     = 9'd0;
         bit_in     = 3'd7;
      end else if (fe_state_ff == FE_DIV) begin
         rem_in = (rem_shift >= divisor) ? rem_shift - divisor : rem_shift;
         bit_in = bit_ff - 3'd1;
      end
   end

   // tick update
   always_comb begin
      for (int b = 0; b < 4; b++) begin
         hist_in[b] = {hist_ff[b][DEBOUNCE_SAMPLES-2:0], pressed_ff[b]};
         if (&hist_in[b])
            deb_in[b] = 1'b1;
         else if (~|hist_in[b])
            deb_in[b] = 1'b0;
         else
            deb_in[b] = deb_ff[b];
      end
      edge_det = deb_in & ~prev_ff;

      prev_in  = prev_ff;
      led_in   = led_ff;
      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      blink_in = blink_ff;
      task_out = '0;

      case (mode_ff)
         MODE_NORMAL: begin
            task_out.toggle = edge_det[3:1];
            led_in          = led_ff ^ edge_det[3:1];
            prev_in[3:1]    = deb_in[3:1];
            if (edge_det[0]) begin
               task_out.stop_seq = 1'b1;
               mode_in           = MODE_STOPPED;
               cnt_in            = 8'd0;
            end
         end
         MODE_STOPPED: begin
            if (|edge_det[3:1]) begin
               mode_in = MODE_BLINKING;
               cnt_in  = 8'd0;
            end
            prev_in[3:1] = deb_in[3:1];
            if (edge_det[0]) begin
               task_out.norm_seq = 1'b1;
               mode_in           = MODE_NORMAL;
               cnt_in            = 8'd0;
            end
         end
         MODE_BLINKING: begin
            if (rem_ff == 9'd0)
               blink_in = ~blink_ff;
            cnt_in = cnt_next;
            if (cnt_next >= blink_duration) begin
               task_out.stop_seq = 1'b1;
               mode_in           = MODE_STOPPED;
               cnt_in            = 8'd0;
            end
            if (edge_det[0]) begin
               task_out.norm_seq = 1'b1;
               mode_in           = MODE_NORMAL;
               cnt_in            = 8'd0;
            end
         end
         default: ;
      endcase
      prev_in[0] = deb_in[0];

      task_out.leds  = led_in;
      task_out.mode  = mode_in;
      task_out.blink = blink_in;
   end

   assign push_data = task_out;

   always_ff @(posedge clock) begin
      pressed_ff <= pressed_in;
      rem_ff     <= rem_in;
      bit_ff     <= bit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fe_state_ff <= FE_IDLE;
         for (int b = 0; b < 4; b++) hist_ff[b] <= '0;
         deb_ff   <= '0;
         prev_ff  <= '0;
         led_ff   <= '0;
         mode_ff  <= MODE_NORMAL;
         cnt_ff   <= '0;
         blink_ff <= 1'b0;
      end else begin
         fe_state_ff <= fe_state_in;
         if (commit) begin
            for (int b = 0; b < 4; b++) hist_ff[b] <= hist_in[b];
            deb_ff   <= deb_in;
            prev_ff  <= prev_in;
            led_ff   <= led_in;
            mode_ff  <= mode_in;
            cnt_ff   <= cnt_in;
            blink_ff <= blink_in;
         end
      end
   end

endmodule

/* rtl/dblmc_queue.sv */
// Short task queue between the front end and the result sequencer.
module dblmc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dblmc_pkg::task_type push_data,
   output logic                full,
   input  logic                pop,
   output dblmc_pkg::task_type head_data,
   output logic                empty
);
   import dblmc_pkg::*;

   task_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/dblmc_back.sv */
// Result sequencer: walks a task's slots and sends one beat per enabled slot.
module dblmc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  dblmc_pkg::task_type head_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output dblmc_pkg::rsp_type  rsp_data
);
   import dblmc_pkg::*;

   // slot order: LED1..3 toggles, stop sequence, normal sequence, status
   localparam logic [3:0] SLOT_TOG1   = 4'd0;
   localparam logic [3:0] SLOT_TOG2   = 4'd1;
   localparam logic [3:0] SLOT_TOG3   = 4'd2;
   localparam logic [3:0] SLOT_STOP0  = 4'd3;
   localparam logic [3:0] SLOT_STOP1  = 4'd4;
   localparam logic [3:0] SLOT_STOP2  = 4'd5;
   localparam logic [3:0] SLOT_STOP3  = 4'd6;
   localparam logic [3:0] SLOT_NORM0  = 4'd7;
   localparam logic [3:0] SLOT_NORM1  = 4'd8;
   localparam logic [3:0] SLOT_NORM2  = 4'd9;
   localparam logic [3:0] SLOT_NORM3  = 4'd10;
   localparam logic [3:0] SLOT_STATUS = 4'd11;

   logic [3:0] slot_ff, slot_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic       out_free;
   logic       slot_en;
   logic       advance;
   logic       load;
   logic [7:0] code;
   rsp_type    beat;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      slot_en = 1'b0;
      code    = CODE_NONE;
      case (slot_ff)
         SLOT_TOG1: begin
            slot_en = head_data.toggle[0];
            code    = head_data.leds[0] ? CODE_LED1_ON : CODE_LED1_OFF;
         end
         SLOT_TOG2: begin
            slot_en = head_data.toggle[1];
            code    = head_data.leds[1] ? CODE_LED2_ON : CODE_LED2_OFF;
         end
         SLOT_TOG3: begin
            slot_en = head_data.toggle[2];
            code    = head_data.leds[2] ? CODE_LED3_ON : CODE_LED3_OFF;
         end
         SLOT_STOP0: begin
            slot_en = head_data.stop_seq;
            code    = CODE_LED1_OFF;
         end
         SLOT_STOP1: begin
            slot_en = head_data.stop_seq;
            code    = CODE_LED2_OFF;
         end
         SLOT_STOP2: begin
            slot_en = head_data.stop_seq;
            code    = CODE_LED3_OFF;
         end
         SLOT_STOP3: begin
            slot_en = head_data.stop_seq;
            code    = CODE_LED0_ON;
         end
         SLOT_NORM0: begin
            slot_en = head_data.norm_seq;
            code    = CODE_LED0_OFF;
         end
         SLOT_NORM1: begin
            slot_en = head_data.norm_seq;
            code    = head_data.leds[0] ? CODE_LED1_ON : CODE_LED1_OFF;
         end
         SLOT_NORM2: begin
            slot_en = head_data.norm_seq;
            code    = head_data.leds[1] ? CODE_LED2_ON : CODE_LED2_OFF;
         end
         SLOT_NORM3: begin
            slot_en = head_data.norm_seq;
            code    = head_data.leds[2] ? CODE_LED3_ON : CODE_LED3_OFF;
         end
         SLOT_STATUS: slot_en = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      beat = '0;
      if (slot_ff == SLOT_STATUS) begin
         beat.mode_now     = head_data.mode;
         beat.led1_on      = head_data.leds[0];
         beat.led2_on      = head_data.leds[1];
         beat.led3_on      = head_data.leds[2];
         beat.blink_level  = head_data.blink;
         beat.last_of_tick = 1'b1;
      end else begin
         beat.is_code   = 1'b1;
         beat.code_byte = code;
      end
   end

   // disabled slots are skipped even while the output is held
   assign advance = !empty && (!slot_en || out_free);
   assign load    = advance && slot_en;
   assign pop     = advance && (slot_ff == SLOT_STATUS);

   always_comb begin
      slot_in = slot_ff;
      if (advance)
         slot_in = (slot_ff == SLOT_STATUS) ? SLOT_TOG1 : slot_ff + 4'd1;
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = load ? beat : rsp_data_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= SLOT_TOG1;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/debounced_button_led_mode_controller_core.sv */
// Top level of the debounced button LED mode controller.
//
//   channel | ports               | direction | beat
//   --------+---------------------+-----------+-----------------------------------
//   req     | req_valid/req_stall | in        | one 10 ms tick, four raw buttons
//   rsp     | rsp_valid/rsp_stall | out       | LED code bytes, then one status
//   csr     | csr_valid/csr_ready | in        | blink_period / blink_duration write
//
// The front end takes a tick in steps: accept, a bit-serial remainder of the
// blink counter by the period, then commit and queue; it takes no new tick until
// the last one is queued. The sequencer spends one cycle per result slot, 12
// slots per tick, while the queue holds a task and rsp does not hold an enabled
// slot's beat; disabled slots are skipped. Reset is synchronous and clears the
// control state at once; datapath registers are not reset. A two-entry queue
// lets the front end keep taking ticks while rsp is stalled, until it fills.
module debounced_button_led_mode_controller_core #(
   parameter int DEBOUNCE_SAMPLES = dblmc_pkg::DEBOUNCE_SAMPLES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dblmc_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dblmc_pkg::rsp_type                  rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dblmc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [7:0]                          csr_wdata
);
   import dblmc_pkg::*;

   logic [7:0] blink_period_ff, blink_period_in;
   logic [7:0] blink_duration_ff, blink_duration_in;

   logic       push_valid;
   task_type   push_data;
   logic       queue_full;
   logic       queue_empty;
   logic       queue_pop;
   task_type   head_data;

   assign csr_ready = 1'b1;

   always_comb begin
      blink_period_in   = blink_period_ff;
      blink_duration_in = blink_duration_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BLINK_PERIOD:   blink_period_in   = csr_wdata;
            CSR_BLINK_DURATION: blink_duration_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blink_period_ff   <= BLINK_PERIOD_RESET;
         blink_duration_ff <= BLINK_DURATION_RESET;
      end else begin
         blink_period_ff   <= blink_period_in;
         blink_duration_ff <= blink_duration_in;
      end
   end

   dblmc_front #(
      .DEBOUNCE_SAMPLES (DEBOUNCE_SAMPLES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .blink_period   (blink_period_ff),
      .blink_duration (blink_duration_ff),
      .push_valid     (push_valid),
      .push_data      (push_data),
      .queue_full     (queue_full)
   );

   dblmc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .head_data (head_data),
      .empty     (queue_empty)
   );

   dblmc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (queue_empty),
      .head_data (head_data),
      .pop       (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/dblmc_checker.sv */
// Port-level checks of the result channel, bound to the top level.
module dblmc_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input dblmc_pkg::rsp_type rsp_data
);
   import dblmc_pkg::*;

   // a held beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // exactly one of code or end-of-tick status
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.is_code != rsp_data.last_of_tick)
      else $error("rsp beat is neither code nor status");

   // code beats carry only the code byte, an LED command
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_code |->
         rsp_data.code_byte >= CODE_LED0_ON && rsp_data.code_byte <= CODE_LED3_OFF &&
         rsp_data.mode_now == MODE_NORMAL && !rsp_data.led1_on && !rsp_data.led2_on &&
         !rsp_data.led3_on && !rsp_data.blink_level)
      else $error("bad code beat");

   // status beats carry a real mode and no code
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_of_tick |->
         rsp_data.code_byte == CODE_NONE && rsp_data.mode_now <= MODE_BLINKING)
      else $error("bad status beat");

endmodule

bind debounced_button_led_mode_controller_core dblmc_checker u_dblmc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
